@@ rtl/core/jpeg_marker_scanner_unit_assert.svh @@
`ifndef JPEG_MARKER_SCANNER_UNIT_ASSERT_SVH
`define JPEG_MARKER_SCANNER_UNIT_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define JMS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("jms assertion failed");

// check the consequent in the cycle after the antecedent
`define JMS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("jms assertion failed");

`endif

@@ rtl/core/jms_pkg.sv @@
package jms_pkg;

  localparam int unsigned OffsetBits = 24;
  localparam int unsigned OutOffW    = 24;
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned PtrW       = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);

  typedef logic [OffsetBits-1:0] pos_t;
  localparam pos_t PosMax = '1;

  localparam logic [7:0] BytePrefix = 8'hFF;
  localparam logic [7:0] ByteStuff  = 8'h00;
  localparam logic [7:0] MarkSof    = 8'hC0;
  localparam logic [7:0] MarkDht    = 8'hC4;
  localparam logic [7:0] MarkRst0   = 8'hD0;
  localparam logic [7:0] MarkRst7   = 8'hD7;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkDqt    = 8'hDB;
  localparam logic [7:0] CompId420  = 8'h21;

  localparam logic [15:0] LenMin = 16'd2;

  localparam logic [3:0] SegHeightHi = 4'd1;
  localparam logic [3:0] SegHeightLo = 4'd2;
  localparam logic [3:0] SegWidthHi  = 4'd3;
  localparam logic [3:0] SegWidthLo  = 4'd4;
  localparam logic [3:0] SegCompId   = 4'd7;
  localparam logic [3:0] SegLast     = 4'd15;

  localparam logic [1:0] ChromaMode420   = 2'd0;
  localparam logic [1:0] ChromaModeOther = 2'd2;

  typedef enum logic [2:0] {
    PH_SCAN   = 3'd0,
    PH_MARKER = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_NOBODY = 3'd1,
    CLS_EOI    = 3'd2,
    CLS_RST    = 3'd3,
    CLS_DQT    = 3'd4,
    CLS_DHT    = 3'd5,
    CLS_SOF    = 3'd6,
    CLS_SOS    = 3'd7
  } mark_cls_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_prefix;
    mark_cls_e  cls;
  } item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_status_t;

  typedef struct packed {
    phase_e      phase;
    pos_t        pos;
    logic        ovf;
    mark_cls_e   cls;
    logic [7:0]  len_hi;
    logic [15:0] skip;
    logic [3:0]  seg;
    pos_t        quant;
    pos_t        huff;
    pos_t        frame;
    pos_t        scan;
    logic        rst_seen;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  comp;
    logic        found;
  } parse_state_t;

endpackage

@@ rtl/core/jpeg_marker_scanner_unit.sv @@
// JPEG marker scanner.
// Input channel: one file byte per word on data_byte_i, with start_req_i set on
// byte 0 of a new file; a word moves when in_valid_i is high and in_stall_o low.
// Output channel: one result word per image, on the EOI marker, carrying the
// DQT/DHT/SOF payload offsets, the scan data offset, frame size, chroma mode
// and status flags; it moves when out_valid_o is high and out_stall_i low.
// Throughput, while no pending result is stalled: one byte per cycle. The front
// stage classifies each byte and writes it into a two-entry queue; the parser
// pops one byte per cycle. The EOI byte is first written into the queue; once
// the parser pops it, the result and out_valid_o are registered.
// Reset clears the parser state as for a fresh file, empties the queue and
// drops any pending result. While the receiver stalls a pending result, the
// parser holds, the queue fills, and in_stall_o rises once it holds two bytes.
// Bytes after EOI are dropped until a byte arrives with start_req_i set.
module jpeg_marker_scanner_unit import jms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] quant_offset_o,
  output logic [23:0] huff_offset_o,
  output logic [23:0] frame_offset_o,
  output logic [23:0] scan_data_offset_o,
  output logic        restart_seen_o,
  output logic [1:0]  chroma_mode_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        frame_seen_o,
  output logic        offset_overflow_o
);

  fifo_status_t status;
  item_t        push_item;
  item_t        head;
  logic         push;
  logic         pop;

  jms_classify u_classify (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .status_i    (status),
    .push_o      (push),
    .item_o      (push_item)
  );

  jms_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  jms_parse u_parse (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .status_i           (status),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .quant_offset_o     (quant_offset_o),
    .huff_offset_o      (huff_offset_o),
    .frame_offset_o     (frame_offset_o),
    .scan_data_offset_o (scan_data_offset_o),
    .restart_seen_o     (restart_seen_o),
    .chroma_mode_o      (chroma_mode_o),
    .image_width_o      (image_width_o),
    .image_height_o     (image_height_o),
    .frame_seen_o       (frame_seen_o),
    .offset_overflow_o  (offset_overflow_o)
  );

endmodule

@@ rtl/core/jms_classify.sv @@
module jms_classify import jms_pkg::*; (
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   data_byte_i,
  input  logic         start_req_i,
  input  fifo_status_t status_i,
  output logic         push_o,
  output item_t        item_o
);

  mark_cls_e cls;

  always_comb begin
    if (data_byte_i == ByteStuff || data_byte_i == MarkSoi) begin
      cls = CLS_NOBODY;
    end else if (data_byte_i == MarkEoi) begin
      cls = CLS_EOI;
    end else if (data_byte_i >= MarkRst0 && data_byte_i <= MarkRst7) begin
      cls = CLS_RST;
    end else if (data_byte_i == MarkDqt) begin
      cls = CLS_DQT;
    end else if (data_byte_i == MarkDht) begin
      cls = CLS_DHT;
    end else if (data_byte_i == MarkSof) begin
      cls = CLS_SOF;
    end else if (data_byte_i == MarkSos) begin
      cls = CLS_SOS;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_stall_o       = status_i.full;
  assign push_o           = in_valid_i && !status_i.full;
  assign item_o.data      = data_byte_i;
  assign item_o.start     = start_req_i;
  assign item_o.is_prefix = (data_byte_i == BytePrefix);
  assign item_o.cls       = cls;

endmodule

@@ rtl/core/jms_fifo.sv @@
`include "jpeg_marker_scanner_unit_assert.svh"

module jms_fifo import jms_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  item_t        item_i,
  input  logic         pop_i,
  output item_t        head_o,
  output fifo_status_t status_o
);

  item_t            mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign status_o.full      = (count_q == CntW'(FifoDepth));
  assign status_o.not_empty = (count_q != '0);
  assign head_o             = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `JMS_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, count_q != CntW'(FifoDepth))
  `JMS_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, count_q != '0)
  `JMS_ASSERT_NOW(a_empty_ptrs, clk_i, rst_ni, count_q == '0, wr_ptr_q == rd_ptr_q)

endmodule

@@ rtl/core/jms_parse.sv @@
`include "jpeg_marker_scanner_unit_assert.svh"

module jms_parse import jms_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  item_t        head_i,
  input  fifo_status_t status_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [23:0]  quant_offset_o,
  output logic [23:0]  huff_offset_o,
  output logic [23:0]  frame_offset_o,
  output logic [23:0]  scan_data_offset_o,
  output logic         restart_seen_o,
  output logic [1:0]   chroma_mode_o,
  output logic [15:0]  image_width_o,
  output logic [15:0]  image_height_o,
  output logic         frame_seen_o,
  output logic         offset_overflow_o
);

  parse_state_t st_q, st_d, cur;
  logic         emit;
  logic         active;
  logic [15:0]  len_raw, len_c, add;
  logic [OffsetBits:0] sum;
  pos_t         sat;
  logic         sat_ovf;
  logic [15:0]  skip_m1;

  logic         out_valid_q, out_valid_d;
  logic [23:0]  quant_q, huff_q, frame_q, scan_q;
  logic         rst_seen_q, found_q, ovf_q;
  logic [1:0]   chroma_q;
  logic [15:0]  width_q, height_q;

  assign pop_o = status_i.not_empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    cur     = head_i.start ? parse_state_t'('0) : st_q;
    st_d    = cur;
    emit    = 1'b0;
    active  = (cur.phase != PH_DONE);
    len_raw = {cur.len_hi, head_i.data};
    len_c   = (len_raw < LenMin) ? LenMin : len_raw;
    add     = (cur.phase == PH_LEN_LO) ? (len_c - 16'd1) : 16'd3;
    sum     = {1'b0, cur.pos} + {{(OffsetBits + 1 - 16){1'b0}}, add};
    sat_ovf = sum[OffsetBits];
    sat     = sat_ovf ? PosMax : sum[OffsetBits-1:0];
    skip_m1 = cur.skip - 16'd1;

    unique case (cur.phase)
      PH_SCAN: begin
        if (head_i.is_prefix) begin
          st_d.phase = PH_MARKER;
        end
      end
      PH_MARKER: begin
        st_d.cls = head_i.cls;
        unique case (head_i.cls)
          CLS_NOBODY: st_d.phase = PH_SCAN;
          CLS_EOI: begin
            st_d.phase = PH_DONE;
            emit       = 1'b1;
          end
          CLS_RST: begin
            st_d.rst_seen = 1'b1;
            st_d.phase    = PH_SCAN;
          end
          CLS_DQT: begin
            st_d.quant = sat;
            st_d.ovf   = cur.ovf | sat_ovf;
            st_d.phase = PH_LEN_HI;
          end
          CLS_DHT: begin
            st_d.huff  = sat;
            st_d.ovf   = cur.ovf | sat_ovf;
            st_d.phase = PH_LEN_HI;
          end
          CLS_SOF: begin
            st_d.frame  = sat;
            st_d.ovf    = cur.ovf | sat_ovf;
            st_d.found  = 1'b1;
            st_d.height = '0;
            st_d.width  = '0;
            st_d.comp   = '0;
            st_d.phase  = PH_LEN_HI;
          end
          default: st_d.phase = PH_LEN_HI;
        endcase
      end
      PH_LEN_HI: begin
        st_d.len_hi = head_i.data;
        st_d.phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (cur.cls == CLS_SOS) begin
          st_d.scan = sat;
          st_d.ovf  = cur.ovf | sat_ovf;
        end
        st_d.seg   = '0;
        st_d.skip  = len_c - LenMin;
        st_d.phase = (len_c != LenMin) ? PH_SKIP : PH_SCAN;
      end
      PH_SKIP: begin
        if (cur.cls == CLS_SOF) begin
          unique case (cur.seg)
            SegHeightHi: st_d.height[15:8] = head_i.data;
            SegHeightLo: st_d.height[7:0]  = head_i.data;
            SegWidthHi:  st_d.width[15:8]  = head_i.data;
            SegWidthLo:  st_d.width[7:0]   = head_i.data;
            SegCompId:   st_d.comp         = head_i.data;
            default: ;
          endcase
        end
        if (cur.seg != SegLast) begin
          st_d.seg = cur.seg + 4'd1;
        end
        st_d.skip = skip_m1;
        if (skip_m1 == '0) begin
          st_d.phase = PH_SCAN;
        end
      end
      PH_DONE: ;
      default: st_d.phase = PH_SCAN;
    endcase

    if (active && !emit) begin
      if (cur.pos != PosMax) begin
        st_d.pos = cur.pos + pos_t'(1);
      end else begin
        st_d.ovf = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        st_q <= st_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      quant_q    <= OutOffW'(cur.quant);
      huff_q     <= OutOffW'(cur.huff);
      frame_q    <= OutOffW'(cur.frame);
      scan_q     <= OutOffW'(cur.scan);
      rst_seen_q <= cur.rst_seen;
      chroma_q   <= (cur.comp == CompId420) ? ChromaMode420 : ChromaModeOther;
      width_q    <= cur.width;
      height_q   <= cur.height;
      found_q    <= cur.found;
      ovf_q      <= cur.ovf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign quant_offset_o     = quant_q;
  assign huff_offset_o      = huff_q;
  assign frame_offset_o     = frame_q;
  assign scan_data_offset_o = scan_q;
  assign restart_seen_o     = rst_seen_q;
  assign chroma_mode_o      = chroma_q;
  assign image_width_o      = width_q;
  assign image_height_o     = height_q;
  assign frame_seen_o       = found_q;
  assign offset_overflow_o  = ovf_q;

  `JMS_ASSERT_NEXT(a_done_after_eoi, clk_i, rst_ni, pop_o && emit, st_q.phase == PH_DONE)
  `JMS_ASSERT_NOW(a_hold_when_blocked, clk_i, rst_ni, out_valid_q && out_stall_i, !pop_o)

endmodule

@@ verif/tb_jpeg_marker_scanner_unit.sv @@
`timescale 1ns / 100ps

module tb_jpeg_marker_scanner_unit;
  import jms_pkg::*;

  localparam int CycleLimit = 500000;

  typedef struct {
    logic       pause;
    logic [7:0] data;
    logic       start;
  } feed_word_t;

  typedef struct {
    logic [23:0] quant;
    logic [23:0] huff;
    logic [23:0] frame;
    logic [23:0] scan;
    logic        restart;
    logic [1:0]  chroma;
    logic [15:0] width;
    logic [15:0] height;
    logic        frame_seen;
    logic        ovf;
  } image_summary_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic start_req = 1'b0;
  logic out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [23:0] quant_offset_o;
  logic [23:0] huff_offset_o;
  logic [23:0] frame_offset_o;
  logic [23:0] scan_data_offset_o;
  logic        restart_seen_o;
  logic [1:0]  chroma_mode_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        frame_seen_o;
  logic        offset_overflow_o;

  jpeg_marker_scanner_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte),
    .start_req_i        (start_req),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .quant_offset_o     (quant_offset_o),
    .huff_offset_o      (huff_offset_o),
    .frame_offset_o     (frame_offset_o),
    .scan_data_offset_o (scan_data_offset_o),
    .restart_seen_o     (restart_seen_o),
    .chroma_mode_o      (chroma_mode_o),
    .image_width_o      (image_width_o),
    .image_height_o     (image_height_o),
    .frame_seen_o       (frame_seen_o),
    .offset_overflow_o  (offset_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  feed_word_t     byte_feed[$];
  image_summary_t pending_summaries[$];
  logic           start_pending;
  logic           byte_taken = 1'b0;
  int             mismatches = 0;
  int             results_seen = 0;
  int             cycle_count = 0;
  int             send_gap = 0;
  int             send_calm = 0;
  int             stall_left = 0;
  int             recv_calm = 0;
  int             long_stall_left = 0;
  int             holds_done = 0;

  phase_e      scan_phase;
  pos_t        file_pos;
  logic        pos_sat;
  logic [7:0]  seg_marker;
  logic [7:0]  len_msb;
  logic [15:0] bytes_to_skip;
  logic [3:0]  field_idx;
  pos_t        dqt_at;
  pos_t        dht_at;
  pos_t        sof_at;
  pos_t        data_at;
  logic        saw_restart;
  logic [15:0] cap_height;
  logic [15:0] cap_width;
  logic [7:0]  cap_comp;
  logic        saw_sof;

  function automatic void clear_parser();
    scan_phase = PH_SCAN;
    file_pos = '0;
    pos_sat = 1'b0;
    seg_marker = 8'd0;
    len_msb = 8'd0;
    bytes_to_skip = 16'd0;
    field_idx = 4'd0;
    dqt_at = '0;
    dht_at = '0;
    sof_at = '0;
    data_at = '0;
    saw_restart = 1'b0;
    cap_height = 16'd0;
    cap_width = 16'd0;
    cap_comp = 8'd0;
    saw_sof = 1'b0;
  endfunction

  function automatic pos_t offset_from(pos_t base, logic [16:0] add);
    logic [OffsetBits:0] sum;
    sum = base + add;
    if (sum > PosMax) begin
      pos_sat = 1'b1;
      return PosMax;
    end
    return sum[OffsetBits-1:0];
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic start);
    logic [15:0]    seg_len;
    image_summary_t s;
    if (start) clear_parser();
    if (scan_phase == PH_DONE) return;
    case (scan_phase)
      PH_SCAN: begin
        if (b == BytePrefix) scan_phase = PH_MARKER;
      end
      PH_MARKER: begin
        seg_marker = b;
        if (b == ByteStuff || b == MarkSoi) begin
          scan_phase = PH_SCAN;
        end else if (b == MarkEoi) begin
          scan_phase = PH_DONE;
          s.quant = dqt_at;
          s.huff = dht_at;
          s.frame = sof_at;
          s.scan = data_at;
          s.restart = saw_restart;
          s.chroma = (cap_comp == CompId420) ? ChromaMode420 : ChromaModeOther;
          s.width = cap_width;
          s.height = cap_height;
          s.frame_seen = saw_sof;
          s.ovf = pos_sat;
          pending_summaries.push_back(s);
          return;
        end else if (b >= MarkRst0 && b <= MarkRst7) begin
          saw_restart = 1'b1;
          scan_phase = PH_SCAN;
        end else begin
          if (b == MarkDqt) begin
            dqt_at = offset_from(file_pos, 17'd3);
          end else if (b == MarkDht) begin
            dht_at = offset_from(file_pos, 17'd3);
          end else if (b == MarkSof) begin
            sof_at = offset_from(file_pos, 17'd3);
            saw_sof = 1'b1;
            cap_height = 16'd0;
            cap_width = 16'd0;
            cap_comp = 8'd0;
          end
          scan_phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_msb = b;
        scan_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len = {len_msb, b};
        if (seg_len < LenMin) seg_len = LenMin;
        if (seg_marker == MarkSos) data_at = offset_from(file_pos, 17'(seg_len - 16'd1));
        field_idx = 4'd0;
        bytes_to_skip = seg_len - LenMin;
        if (bytes_to_skip != 16'd0) scan_phase = PH_SKIP;
        else scan_phase = PH_SCAN;
      end
      PH_SKIP: begin
        if (seg_marker == MarkSof) begin
          case (field_idx)
            SegHeightHi: cap_height[15:8] = b;
            SegHeightLo: cap_height[7:0] = b;
            SegWidthHi:  cap_width[15:8] = b;
            SegWidthLo:  cap_width[7:0] = b;
            SegCompId:   cap_comp = b;
            default: ;
          endcase
        end
        if (field_idx < SegLast) field_idx++;
        bytes_to_skip--;
        if (bytes_to_skip == 16'd0) scan_phase = PH_SCAN;
      end
      default: scan_phase = PH_SCAN;
    endcase
    if (file_pos < PosMax) file_pos++;
    else pos_sat = 1'b1;
  endtask

  task automatic put(input logic [7:0] b);
    feed_word_t w;
    w.pause = 1'b0;
    w.data = b;
    w.start = start_pending;
    start_pending = 1'b0;
    byte_feed.push_back(w);
  endtask

  task automatic add_segment(input logic [7:0] code, input int body_len);
    logic [15:0] seg_len;
    logic [7:0]  b;
    seg_len = 16'(body_len + 2);
    put(BytePrefix);
    put(code);
    put(seg_len[15:8]);
    put(seg_len[7:0]);
    for (int i = 0; i < body_len; i++) begin
      b = ($urandom_range(0, 6) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      if (code == MarkSof && i == 7 && $urandom_range(0, 1) == 1) b = CompId420;
      put(b);
    end
  endtask

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at cycle %0d: expected %0h, got %0h", name, cycle_count,
                 want, got);
    end
  endtask

  always @(posedge clk_i) begin
    image_summary_t want;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        byte_taken = 1'b1;
        parse_byte(data_byte, start_req);
      end
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (pending_summaries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycle_count);
        end else begin
          want = pending_summaries.pop_front();
          check_field("quant_offset", want.quant, quant_offset_o);
          check_field("huff_offset", want.huff, huff_offset_o);
          check_field("frame_offset", want.frame, frame_offset_o);
          check_field("scan_data_offset", want.scan, scan_data_offset_o);
          check_field("restart_seen", 24'(want.restart), 24'(restart_seen_o));
          check_field("chroma_mode", 24'(want.chroma), 24'(chroma_mode_o));
          check_field("image_width", 24'(want.width), 24'(image_width_o));
          check_field("image_height", 24'(want.height), 24'(image_height_o));
          check_field("frame_seen", 24'(want.frame_seen), 24'(frame_seen_o));
          check_field("offset_overflow", 24'(want.ovf), 24'(offset_overflow_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    feed_word_t w;
    if (rst_ni && !(in_valid && !byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_feed.size() != 0 && byte_feed[0].pause) begin
        in_valid <= 1'b0;
        if (pending_summaries.size() == 0) void'(byte_feed.pop_front());
      end else if (byte_feed.size() != 0) begin
        w = byte_feed.pop_front();
        data_byte <= w.data;
        start_req <= w.start;
        in_valid <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_stall_left == 0 && holds_done < 2 && out_valid_o &&
          results_seen >= ((holds_done == 0) ? 3 : 20)) begin
        long_stall_left = 400;
        holds_done++;
      end
      if (long_stall_left > 0) begin
        long_stall_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(recv_calm);
      end
    end
  end

  initial begin
    int         files;
    int         n;
    logic [7:0] b;
    feed_word_t hold_word;
    clear_parser();
    hold_word.pause = 1'b1;
    hold_word.data = 8'd0;
    hold_word.start = 1'b0;

    // first file parsed without a start flag: short SOF, restart, no body markers
    start_pending = 1'b0;
    put(BytePrefix); put(MarkSoi);
    put(BytePrefix); put(MarkRst0);
    put(BytePrefix); put(MarkSof); put(8'h00); put(8'h01);
    put(BytePrefix); put(MarkEoi);
    // dropped after end of image
    put(BytePrefix); put(MarkEoi);
    // no SOF, EOI hidden in a body, doubled prefix, zero length
    start_pending = 1'b1;
    put(BytePrefix); put(MarkDqt); put(8'h00); put(8'h04); put(BytePrefix); put(MarkEoi);
    put(BytePrefix); put(BytePrefix); put(8'h00); put(8'h00);
    put(BytePrefix); put(MarkEoi);

    files = 0;
    while (byte_feed.size() < 1250 || files < 40) begin
      start_pending = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) put(8'($urandom_range(0, 255)));
      end
      put(BytePrefix);
      put(MarkSoi);
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1: add_segment(MarkDqt, $urandom_range(0, 8));
          2: add_segment(MarkDht, $urandom_range(0, 8));
          3, 4: begin
            if ($urandom_range(0, 3) == 0) add_segment(MarkSof, $urandom_range(0, 7));
            else add_segment(MarkSof, $urandom_range(8, 14));
          end
          5: begin
            if ($urandom_range(0, 29) == 0) add_segment(8'($urandom_range(0, 255)),
                                                        $urandom_range(200, 300));
            else add_segment(8'($urandom_range(0, 255)), $urandom_range(0, 6));
          end
          6: begin
            put(BytePrefix);
            put(MarkRst0 + 8'($urandom_range(0, 7)));
          end
          7: begin
            put(BytePrefix);
            case ($urandom_range(0, 2))
              0: put(MarkDqt);
              1: put(MarkSos);
              default: put(MarkSof);
            endcase
            put(8'h00);
            put(8'($urandom_range(0, 1)));
          end
          8: begin
            add_segment(MarkSos, $urandom_range(0, 6));
            n = $urandom_range(0, 12);
            repeat (n) begin
              b = 8'($urandom_range(0, 255));
              put(b);
              if (b == BytePrefix) begin
                if ($urandom_range(0, 1) == 0) put(ByteStuff);
                else put(MarkRst0 + 8'($urandom_range(0, 7)));
              end
            end
          end
          default: begin
            put(BytePrefix);
            put(ByteStuff);
          end
        endcase
      end
      if ($urandom_range(0, 9) != 0) begin
        put(BytePrefix);
        put(MarkEoi);
      end
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) put(8'($urandom_range(0, 255)));
      end
      files++;
      if (files % 20 == 10) byte_feed.push_back(hold_word);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_feed.size() != 0 || in_valid || pending_summaries.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    mismatches += pending_summaries.size();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
